[rtl/kdsl_pkg.sv]
// ----------------------------------------------------------------------------
// kdsl_pkg: shared types and constants for the keypad debounce block
// Field widths, register codes, reset values and the per-key entry layout.
// ----------------------------------------------------------------------------
package kdsl_pkg;

  localparam int KEYS_DEF   = 9;
  localparam int MS_W       = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int MEDIA_W    = 7;
  localparam int MEDIA_KEYS = 7;
  localparam int LIGHT_KEY  = 7;

  // Result queue depth; requests in flight are limited to it.
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK    = 8'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] FLASH_RST    = 16'd80;
  localparam logic [CFG_W-1:0] BLINK_RST    = 16'd500;

  typedef struct packed {
    logic            raw;
    logic            stable;
    logic [MS_W-1:0] chg_time;
  } key_ent_t;

endpackage

[rtl/keypad_debounce_status_led.sv]
// ----------------------------------------------------------------------------
// keypad_debounce_status_led: debounced keypad scanner with status LED
// Per-key debounce state lives in a small synchronous memory that is read,
// updated and written back once per key of each scan request.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  in      | input     | in_valid / in_ready   | raw_keys, now_ms, is_connected
//  out     | output    | out_valid / out_ready | press_mask, media_mask,
//          |           |                       | backlight_on, status_led
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  A scan request issues one memory read-modify-write per key in turn;
//  the next request may be accepted in the cycle that issues the last key.
//  Keys are read in stage A and updated in stage B; stage C queues the result.
//  Results wait in a four-entry queue; at most four requests are in flight,
//  so a stalled output stops input once four requests are unanswered.
//  Reset marks every key entry unwritten, which reads as all zero; no
//  clearing pass is needed. cfg_ready is always high.
// ----------------------------------------------------------------------------
module keypad_debounce_status_led #(
  parameter int KEYS = kdsl_pkg::KEYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [KEYS-1:0]                in_raw_keys,
  input  logic [kdsl_pkg::MS_W-1:0]      in_now_ms,
  input  logic                           in_is_connected,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [KEYS-1:0]                out_press_mask,
  output logic [kdsl_pkg::MEDIA_W-1:0]   out_media_mask,
  output logic                           out_backlight_on,
  output logic                           out_status_led,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kdsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdsl_pkg::CFG_W-1:0]     cfg_data
);

  localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int MS_W = kdsl_pkg::MS_W;
  localparam int MW   = kdsl_pkg::MEDIA_W;
  localparam int EXT  = kdsl_pkg::MS_W - kdsl_pkg::CFG_W;
  localparam int PW   = kdsl_pkg::OUT_PTR_W;
  localparam int CW   = kdsl_pkg::OUT_CNT_W;
  localparam logic [KW-1:0] LAST_KEY = KW'(KEYS - 1);
  localparam logic [CW-1:0] CREDITS  = CW'(kdsl_pkg::OUT_DEPTH);

  // Configuration registers.
  logic [kdsl_pkg::CFG_W-1:0] debounce_r, flash_r, blink_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= kdsl_pkg::DEBOUNCE_RST;
      flash_r    <= kdsl_pkg::FLASH_RST;
      blink_r    <= kdsl_pkg::BLINK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kdsl_pkg::REG_DEBOUNCE: debounce_r <= cfg_data;
        kdsl_pkg::REG_FLASH:    flash_r    <= cfg_data;
        kdsl_pkg::REG_BLINK:    blink_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: request register and key counter, issues one memory read a cycle.
  logic            a_busy_r;
  logic [KW-1:0]   a_key_r;
  logic [KEYS-1:0] a_keys_r;
  logic [MS_W-1:0] a_now_r;
  logic            a_conn_r;
  logic [MS_W-1:0] a_fdl_r;
  logic            a_last;
  logic            in_fire;
  logic            out_fire;
  logic [CW-1:0]   pend_r;

  assign a_last   = (a_key_r == LAST_KEY);
  assign in_ready = (!a_busy_r || a_last) && (pend_r < CREDITS);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_busy_r <= 1'b0;
      a_key_r  <= '0;
    end else if (in_fire) begin
      a_busy_r <= 1'b1;
      a_key_r  <= '0;
    end else if (a_busy_r) begin
      a_busy_r <= !a_last;
      a_key_r  <= a_last ? '0 : a_key_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_keys_r <= in_raw_keys;
      a_now_r  <= in_now_ms;
      a_conn_r <= in_is_connected;
      a_fdl_r  <= in_now_ms + {{EXT{1'b0}}, flash_r};
    end
  end

  // Key state memory with write-to-read forwarding.
  kdsl_pkg::key_ent_t key_mem [KEYS];
  logic [KEYS-1:0]    written_r;
  kdsl_pkg::key_ent_t rd_data_r;
  logic               rd_ok_r;
  logic               wr_en;
  kdsl_pkg::key_ent_t wr_data;
  logic [KW-1:0]      wr_addr;
  logic               fwd;

  assign fwd = wr_en && (wr_addr == a_key_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (a_busy_r) begin
      rd_data_r <= fwd ? wr_data : key_mem[a_key_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (a_busy_r) begin
        rd_ok_r <= fwd || written_r[a_key_r];
      end
    end
  end

  // Stage B: update one key entry and collect the scan's events.
  logic            b_valid_r;
  logic            b_last_r;
  logic [KW-1:0]   b_key_r;
  logic            b_lvl_r;
  logic [MS_W-1:0] b_now_r;
  logic            b_conn_r;
  logic [MS_W-1:0] b_fdl_r;
  logic [KEYS-1:0] press_acc_r, press_nxt;
  logic [MW-1:0]   media_acc_r, media_nxt;
  logic            light_r, light_nxt;
  logic [MS_W-1:0] flash_until_r, flash_until_nxt;

  kdsl_pkg::key_ent_t cur, upd;
  logic [MS_W-1:0]    held;
  logic               settled;
  logic               pressed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_busy_r) begin
      b_last_r <= a_last;
      b_key_r  <= a_key_r;
      b_lvl_r  <= a_keys_r[a_key_r];
      b_now_r  <= a_now_r;
      b_conn_r <= a_conn_r;
      b_fdl_r  <= a_fdl_r;
    end
  end

  always_comb begin
    cur = rd_ok_r ? rd_data_r : '0;
    upd = cur;
    if (b_lvl_r != cur.raw) begin
      upd.raw      = b_lvl_r;
      upd.chg_time = b_now_r;
    end
    held    = b_now_r - upd.chg_time;
    settled = (held >= {{EXT{1'b0}}, debounce_r});
    pressed = 1'b0;
    if (settled && (upd.stable != upd.raw)) begin
      upd.stable = upd.raw;
      pressed    = upd.raw;
    end

    press_nxt       = press_acc_r;
    media_nxt       = media_acc_r;
    light_nxt       = light_r;
    flash_until_nxt = flash_until_r;
    if (b_valid_r && pressed) begin
      press_nxt       = press_acc_r | (KEYS'(1) << b_key_r);
      flash_until_nxt = b_fdl_r;
      if (int'(b_key_r) < kdsl_pkg::MEDIA_KEYS) begin
        if (b_conn_r) begin
          media_nxt = media_acc_r | (MW'(1) << b_key_r);
        end
      end else if (int'(b_key_r) == kdsl_pkg::LIGHT_KEY) begin
        light_nxt = !light_r;
      end
    end
  end

  assign wr_en   = b_valid_r;
  assign wr_addr = b_key_r;
  assign wr_data = upd;

  // Stage C: status LED update once all keys of a scan are done.
  logic            c_valid_r;
  logic [MS_W-1:0] c_now_r;
  logic            c_conn_r;
  logic [KEYS-1:0] c_press_r;
  logic [MW-1:0]   c_media_r;
  logic            phase_r, phase_nxt;
  logic [MS_W-1:0] last_blink_r, last_blink_nxt;
  logic            led_r, led_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_acc_r   <= '0;
      media_acc_r   <= '0;
      light_r       <= 1'b0;
      flash_until_r <= '0;
      c_valid_r     <= 1'b0;
    end else begin
      light_r       <= light_nxt;
      flash_until_r <= flash_until_nxt;
      c_valid_r     <= b_valid_r && b_last_r;
      if (b_valid_r && b_last_r) begin
        press_acc_r <= '0;
        media_acc_r <= '0;
      end else if (b_valid_r) begin
        press_acc_r <= press_nxt;
        media_acc_r <= media_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r && b_last_r) begin
      c_now_r   <= b_now_r;
      c_conn_r  <= b_conn_r;
      c_press_r <= press_nxt;
      c_media_r <= media_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    last_blink_nxt = last_blink_r;
    led_nxt        = led_r;
    if (c_now_r < flash_until_r) begin
      led_nxt = 1'b0;
    end else if (c_conn_r) begin
      led_nxt = 1'b1;
    end else if ((c_now_r - last_blink_r) >= {{EXT{1'b0}}, blink_r}) begin
      last_blink_nxt = c_now_r;
      phase_nxt      = !phase_r;
      led_nxt        = !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 1'b0;
      last_blink_r <= '0;
      led_r        <= 1'b0;
    end else if (c_valid_r) begin
      phase_r      <= phase_nxt;
      last_blink_r <= last_blink_nxt;
      led_r        <= led_nxt;
    end
  end

  // Result queue. Light level is sampled before the next scan's toggle lands.
  logic [KEYS-1:0] q_press [kdsl_pkg::OUT_DEPTH];
  logic [MW-1:0]   q_media [kdsl_pkg::OUT_DEPTH];
  logic            q_light [kdsl_pkg::OUT_DEPTH];
  logic            q_led   [kdsl_pkg::OUT_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign out_valid        = (cnt_r != '0);
  assign out_fire         = out_valid && out_ready;
  assign out_press_mask   = q_press[rp_r];
  assign out_media_mask   = q_media[rp_r];
  assign out_backlight_on = q_light[rp_r];
  assign out_status_led   = q_led[rp_r];

  always_ff @(posedge clk) begin
    if (c_valid_r) begin
      q_press[wp_r] <= c_press_r;
      q_media[wp_r] <= c_media_r;
      q_light[wp_r] <= light_r;
      q_led[wp_r]   <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      pend_r <= '0;
    end else begin
      if (c_valid_r) begin
        wp_r <= wp_r + PW'(1);
      end
      if (out_fire) begin
        rp_r <= rp_r + PW'(1);
      end
      cnt_r  <= cnt_r + CW'(c_valid_r) - CW'(out_fire);
      pend_r <= pend_r + CW'(in_fire) - CW'(out_fire);
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= CREDITS)
    else $error("more requests in flight than the result queue holds");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r |-> (cnt_r < CREDITS) || out_fire)
    else $error("result written into a full queue");

  a_queue_le_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pend_r)
    else $error("queued results exceed requests in flight");

  a_accept_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> a_busy_r && (a_key_r == '0))
    else $error("accepted request did not start at the first key");

endmodule

[tb/keypad_debounce_status_led_checker.sv]
// ----------------------------------------------------------------------------
// keypad_debounce_status_led_checker: scan predictor and result scoreboard
// Watches the scan, result and register channels of the keypad block. Each
// accepted scan request is run through a local debounce and LED model, and
// the expected result is queued. Each accepted result is compared field by
// field against the oldest queued one.
// ----------------------------------------------------------------------------
module keypad_debounce_status_led_checker #(
  parameter int KEYS = kdsl_pkg::KEYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [KEYS-1:0]                in_raw_keys,
  input  logic [kdsl_pkg::MS_W-1:0]      in_now_ms,
  input  logic                           in_is_connected,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [KEYS-1:0]                out_press_mask,
  input  logic [kdsl_pkg::MEDIA_W-1:0]   out_media_mask,
  input  logic                           out_backlight_on,
  input  logic                           out_status_led,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [kdsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdsl_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending_results,
  output int                             scans_checked,
  output int                             presses_seen,
  output int                             media_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MS_W = kdsl_pkg::MS_W;

  typedef struct packed {
    logic [KEYS-1:0]              press;
    logic [kdsl_pkg::MEDIA_W-1:0] media;
    logic                         light;
    logic                         led;
  } scan_result_t;

  // Register copies.
  logic [kdsl_pkg::CFG_W-1:0] settle_ms;
  logic [kdsl_pkg::CFG_W-1:0] flash_ms;
  logic [kdsl_pkg::CFG_W-1:0] blink_ms;

  // Per-key debounce state and LED state.
  logic [KEYS-1:0] raw_lvl;
  logic [KEYS-1:0] stable_lvl;
  logic [MS_W-1:0] chg_at [KEYS];
  logic            light;
  logic            blink_ph;
  logic [MS_W-1:0] last_blink;
  logic [MS_W-1:0] flash_end;
  logic            led;

  scan_result_t expected_scans [$];

  function automatic scan_result_t predict_scan(input logic [KEYS-1:0] keys,
                                                input logic [MS_W-1:0] now,
                                                input logic conn);
    scan_result_t r;
    logic [MS_W-1:0] held;
    r = '0;
    for (int k = 0; k < KEYS; k++) begin
      if (keys[k] != raw_lvl[k]) begin
        raw_lvl[k] = keys[k];
        chg_at[k] = now;
      end
      held = now - chg_at[k];
      if (held >= MS_W'(settle_ms) && stable_lvl[k] != raw_lvl[k]) begin
        stable_lvl[k] = raw_lvl[k];
        // Releases update the state silently; only presses are reported.
        if (stable_lvl[k]) begin
          r.press[k] = 1'b1;
          flash_end = now + MS_W'(flash_ms);
          if (k < kdsl_pkg::MEDIA_KEYS) begin
            if (conn) r.media[k] = 1'b1;
          end else if (k == kdsl_pkg::LIGHT_KEY) begin
            light = ~light;
          end
        end
      end
    end
    // Plain unsigned compare: a deadline that wrapped past zero gives no flash.
    if (now < flash_end) begin
      led = 1'b0;
    end else if (conn) begin
      led = 1'b1;
    end else if (now - last_blink >= MS_W'(blink_ms)) begin
      last_blink = now;
      blink_ph = ~blink_ph;
      led = blink_ph;
    end
    r.light = light;
    r.led = led;
    return r;
  endfunction

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      settle_ms = kdsl_pkg::DEBOUNCE_RST;
      flash_ms = kdsl_pkg::FLASH_RST;
      blink_ms = kdsl_pkg::BLINK_RST;
      raw_lvl = '0;
      stable_lvl = '0;
      for (int k = 0; k < KEYS; k++) chg_at[k] = '0;
      light = 1'b0;
      blink_ph = 1'b0;
      last_blink = '0;
      flash_end = '0;
      led = 1'b0;
      expected_scans.delete();
      fail_count = 0;
      scans_checked = 0;
      presses_seen = 0;
      media_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kdsl_pkg::REG_DEBOUNCE: settle_ms = cfg_data;
          kdsl_pkg::REG_FLASH:    flash_ms = cfg_data;
          kdsl_pkg::REG_BLINK:    blink_ms = cfg_data;
          default:      ;
        endcase
      end
      if (in_valid && in_ready)
        expected_scans.push_back(predict_scan(in_raw_keys, in_now_ms, in_is_connected));
      if (out_valid && out_ready) begin
        if (expected_scans.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] result arrived with no scan request pending", $realtime);
        end else begin
          want = expected_scans.pop_front();
          scans_checked++;
          presses_seen += $countones(want.press);
          media_seen += $countones(want.media);
          if (out_press_mask !== want.press || out_media_mask !== want.media ||
              out_backlight_on !== want.light || out_status_led !== want.led) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] scan %0d: press %h/%h media %h/%h light %b/%b led %b/%b %s",
                       $realtime, scans_checked, want.press, out_press_mask,
                       want.media, out_media_mask, want.light, out_backlight_on,
                       want.led, out_status_led, "(expected/actual)");
          end
        end
      end
    end
    pending_results <= expected_scans.size();
  end

endmodule

[tb/keypad_debounce_status_led_tb.sv]
// ----------------------------------------------------------------------------
// keypad_debounce_status_led_tb: top-level testbench for the keypad block
// Drives directed and random keypad scans through several register settings
// with random idling on both channels and one long output stall. A separate
// checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module keypad_debounce_status_led_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEYS = kdsl_pkg::KEYS_DEF;
  localparam int MS_W = kdsl_pkg::MS_W;
  localparam int LONG_HOLD = 300;
  localparam logic [kdsl_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

  logic clk = 1'b0;
  logic rst_n;

  logic                           in_valid;
  logic                           in_ready;
  logic [KEYS-1:0]                in_raw_keys;
  logic [MS_W-1:0]                in_now_ms;
  logic                           in_is_connected;
  logic                           out_valid;
  logic                           out_ready;
  logic [KEYS-1:0]                out_press_mask;
  logic [kdsl_pkg::MEDIA_W-1:0]   out_media_mask;
  logic                           out_backlight_on;
  logic                           out_status_led;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [kdsl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kdsl_pkg::CFG_W-1:0]     cfg_data;

  int fail_count;
  int pending_results;
  int scans_checked;
  int presses_seen;
  int media_seen;

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;

  // Running scan stream state for the random part.
  logic [KEYS-1:0] cur_keys;
  logic [MS_W-1:0] clock_ms;
  logic            link;
  int              last_key;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keypad_debounce_status_led #(.KEYS(KEYS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_raw_keys(in_raw_keys), .in_now_ms(in_now_ms), .in_is_connected(in_is_connected),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_press_mask(out_press_mask), .out_media_mask(out_media_mask),
    .out_backlight_on(out_backlight_on), .out_status_led(out_status_led),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  keypad_debounce_status_led_checker #(.KEYS(KEYS)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_raw_keys(in_raw_keys), .in_now_ms(in_now_ms), .in_is_connected(in_is_connected),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_press_mask(out_press_mask), .out_media_mask(out_media_mask),
    .out_backlight_on(out_backlight_on), .out_status_led(out_status_led),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_results(pending_results),
    .scans_checked(scans_checked), .presses_seen(presses_seen),
    .media_seen(media_seen)
  );

  // Valid is only dropped when a gap is actually taken, so a back-to-back
  // request keeps it high without a same-step low/high pair.
  task automatic send_scan(input logic [KEYS-1:0] keys, input logic [MS_W-1:0] now,
                           input logic conn);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_keys <= keys;
    in_now_ms <= now;
    in_is_connected <= conn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kdsl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kdsl_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [kdsl_pkg::CFG_W-1:0] deb,
                          input logic [kdsl_pkg::CFG_W-1:0] fl,
                          input logic [kdsl_pkg::CFG_W-1:0] bl);
    write_reg(kdsl_pkg::REG_DEBOUNCE, deb);
    write_reg(kdsl_pkg::REG_FLASH, fl);
    write_reg(kdsl_pkg::REG_BLINK, bl);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (2 * KEYS + 8) @(posedge clk);
  endtask

  // Mostly well-formed key activity on a slowly advancing clock, with some
  // contact bounce, link drops, large time jumps and fully random scans.
  task automatic run_scans(input int count);
    int pick;
    int k;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        cur_keys = KEYS'($urandom);
        clock_ms = $urandom;
        link = 1'($urandom_range(1));
      end else begin
        clock_ms += (pick < 12) ? $urandom_range(2000, 200) : $urandom_range(12, 1);
        if (pick < 40) begin
          k = $urandom_range(KEYS - 1);
          cur_keys[k] = ~cur_keys[k];
          last_key = k;
        end else if (pick < 50) begin
          cur_keys[last_key] = ~cur_keys[last_key];
        end
        if ($urandom_range(99) < 4) link = ~link;
      end
      send_scan(cur_keys, clock_ms, link);
    end
  endtask

  initial begin
    rx_idle_pct = 45;
    out_ready <= 1'b0;
    forever begin : receiver
      int hold_left;
      bit hold_taken;
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    tx_idle_pct = 16;
    hold_req <= 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_raw_keys <= '0;
    in_now_ms <= '0;
    in_is_connected <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cur_keys = '0;
    clock_ms = 32'd5000;
    link = 1'b1;
    last_key = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed scans at the reset register values.
    send_scan('0, 32'd0, 1'b0);
    send_scan('1, 32'd5, 1'b1);
    send_scan('1, 32'd30, 1'b1);          // every key pressed in one scan
    send_scan('1, 32'd120, 1'b1);         // flash over, link up
    send_scan('0, 32'd130, 1'b0);
    send_scan('0, 32'd160, 1'b0);         // release, reported as nothing
    send_scan(9'h001, 32'd200, 1'b0);     // bouncing contact on key 0
    send_scan(9'h000, 32'd205, 1'b0);
    send_scan(9'h001, 32'd210, 1'b0);
    send_scan(9'h001, 32'd240, 1'b0);     // press with the link down
    send_scan(9'h101, 32'd300, 1'b1);
    send_scan(9'h101, 32'd330, 1'b1);     // key 8: press only
    send_scan(9'h181, 32'd400, 1'b1);
    send_scan(9'h181, 32'd430, 1'b1);     // backlight key
    send_scan(9'h000, 32'd1000, 1'b0);    // advertising blink
    send_scan(9'h000, 32'd1600, 1'b0);
    send_scan(9'h000, 32'd1700, 1'b0);
    send_scan(9'h002, 32'hFFFF_FFE0, 1'b1);
    send_scan(9'h002, 32'hFFFF_FFFF, 1'b1); // flash deadline wraps past zero
    send_scan(9'h002, 32'd0, 1'b1);
    send_scan(9'h002, 32'd100, 1'b0);
    run_scans(90);
    wait_idle();

    // Zero debounce and blink, longest flash; an unmapped index is ignored.
    set_regs(16'd0, 16'hFFFF, 16'd0);
    write_reg(REG_UNMAPPED, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    run_scans(80);
    wait_idle();

    // Longest debounce and blink, no flash.
    tx_idle_pct = 45;
    rx_idle_pct = 16;
    set_regs(16'hFFFF, 16'd0, 16'hFFFF);
    run_scans(30);
    wait_idle();

    // Short times across the millisecond wrap, with a long output stall.
    set_regs(16'd5, 16'd30, 16'd50);
    clock_ms = 32'hFFFF_FF00;
    hold_req <= 1'b1;
    run_scans(120);
    wait_idle();

    // Random moderate settings, no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_regs(16'($urandom_range(40, 1)), 16'($urandom_range(200)),
             16'($urandom_range(300, 1)));
    run_scans(170);
    wait_idle();

    $display("Covered %0d keypad scans over five register settings and a long output stall;",
             scans_checked);
    $display("%0d debounced presses and %0d media commands were predicted and compared.",
             presses_seen, media_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("keypad_debounce_status_led test passed");
    end else begin
      $display("keypad_debounce_status_led test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run stopped by the watchdog with %0d results still pending.", pending_results);
    $display("keypad_debounce_status_led test failed");
    $finish;
  end

endmodule
